/* hdl/rwcc_pkg.sv */
// Shared types, constants and helpers for the random word to charset character core.
// No dependencies; every other file in hdl/ imports this package.
package rwcc_pkg;

  localparam int RAND_W        = 64;
  localparam int WORD_BITS_DEF = 64;
  localparam int CHAR_W        = 7;
  localparam int IDX_W         = 7;
  localparam int MASK_W        = 4;

  localparam logic [MASK_W-1:0] MASK_RESET = 4'hF;

  // set_mask bit positions
  localparam int MASK_LOWER  = 0;
  localparam int MASK_UPPER  = 1;
  localparam int MASK_DIGIT  = 2;
  localparam int MASK_SYMBOL = 3;

  localparam logic [IDX_W-1:0] LOWER_COUNT  = 7'd26;
  localparam logic [IDX_W-1:0] UPPER_COUNT  = 7'd26;
  localparam logic [IDX_W-1:0] DIGIT_COUNT  = 7'd10;
  localparam logic [IDX_W-1:0] SYMBOL_COUNT = 7'd32;

  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_FIRST   = 7'h21;  // '!'
  localparam logic [CHAR_W-1:0] CHAR_LAST    = 7'h7E;  // '~'

  typedef struct packed {
    logic [RAND_W-1:0] random_word;
    logic              last_in;
  } in_beat_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              no_set_error;
    logic              last_out;
  } out_beat_t;

  // Registered configuration seen by the datapath
  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic [IDX_W-1:0]  size;
    logic              busy;
  } cfg_t;

  function automatic logic [IDX_W-1:0] set_size(input logic [MASK_W-1:0] mask);
    logic [IDX_W-1:0] n;
    n = '0;
    if (mask[MASK_LOWER])  n = n + LOWER_COUNT;
    if (mask[MASK_UPPER])  n = n + UPPER_COUNT;
    if (mask[MASK_DIGIT])  n = n + DIGIT_COUNT;
    if (mask[MASK_SYMBOL]) n = n + SYMBOL_COUNT;
    return n;
  endfunction

endpackage

/* hdl/rwcc_derive.sv */
// Holds set_mask and derives alphabet size, quantum and accept limit.
// Quantum = top / size via a bit-serial restoring divider; uses rwcc_pkg.
module rwcc_derive #(
  parameter int WORD_BITS = rwcc_pkg::WORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [rwcc_pkg::MASK_W-1:0]  cfg_wdata,
  output rwcc_pkg::cfg_t               cfg,
  output logic [WORD_BITS-1:0]         quantum,
  output logic [WORD_BITS-1:0]         accept_limit
);
  import rwcc_pkg::*;

  localparam int CNT_W = $clog2(WORD_BITS);
  localparam logic [WORD_BITS-1:0] TOP = {WORD_BITS{1'b1}};
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

  logic [MASK_W-1:0]    mask_r;
  logic [IDX_W-1:0]     size_r;
  logic                 busy_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [IDX_W-1:0]     rem_r;
  logic [WORD_BITS-1:0] quo_r;
  logic [WORD_BITS-1:0] quantum_r;
  logic [WORD_BITS-1:0] limit_r;

  logic [IDX_W:0]       rem_sh;
  logic                 ge;
  logic [IDX_W:0]       rem_diff;
  logic [IDX_W-1:0]     rem_nxt;
  logic [WORD_BITS-1:0] quo_nxt;
  logic [IDX_W-1:0]     wr_size;

  // dividend is all ones, so every step shifts in a one
  always_comb begin
    rem_sh   = {rem_r, 1'b1};
    ge       = rem_sh >= {1'b0, size_r};
    rem_diff = rem_sh - {1'b0, size_r};
    rem_nxt  = ge ? rem_diff[IDX_W-1:0] : rem_sh[IDX_W-1:0];
    quo_nxt  = {quo_r[WORD_BITS-2:0], ge};
    wr_size  = set_size(cfg_wdata);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= MASK_RESET;
      size_r <= set_size(MASK_RESET);
      busy_r <= 1'b1;
      cnt_r  <= CNT_LAST;
      rem_r  <= '0;
      quo_r  <= '0;
    end else if (cfg_we) begin
      mask_r <= cfg_wdata;
      size_r <= wr_size;
      cnt_r  <= CNT_LAST;
      rem_r  <= '0;
      quo_r  <= '0;
      if (wr_size == '0) begin
        busy_r    <= 1'b0;
        quantum_r <= '0;
        limit_r   <= '0;
      end else begin
        busy_r <= 1'b1;
      end
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r    <= 1'b0;
        quantum_r <= quo_nxt;
        limit_r   <= TOP - {{(WORD_BITS-IDX_W){1'b0}}, rem_nxt};
      end
    end
  end

  assign cfg.mask     = mask_r;
  assign cfg.size     = size_r;
  assign cfg.busy     = busy_r;
  assign quantum      = quantum_r;
  assign accept_limit = limit_r;

endmodule

/* hdl/rwcc_div_pipe.sv */
// Pipelined index divider: word / quantum, one quotient bit per stage.
// Entry stage plus IDX_W divide stages, per-stage valid/ready; uses rwcc_pkg.
module rwcc_div_pipe #(
  parameter int WORD_BITS = rwcc_pkg::WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [WORD_BITS-1:0]        word,
  input  logic                        last,
  input  logic [WORD_BITS-1:0]        quantum,
  input  logic [WORD_BITS-1:0]        accept_limit,
  input  logic [rwcc_pkg::IDX_W-1:0]  size,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rwcc_pkg::IDX_W-1:0]  out_quo,
  output logic                        out_over,
  output logic                        out_last,
  output logic                        out_err
);
  import rwcc_pkg::*;

  localparam int STEPS = IDX_W;
  localparam int EXT_W = WORD_BITS + IDX_W;

  logic                 v_r    [0:STEPS];
  logic                 rdy    [0:STEPS];
  logic [WORD_BITS-1:0] rem_r  [0:STEPS];
  logic [IDX_W-1:0]     q_r    [0:STEPS];
  logic                 over_r [0:STEPS];
  logic                 last_r [0:STEPS];
  logic                 err_r  [0:STEPS];

  for (genvar s = 0; s <= STEPS; s++) begin : g_rdy
    if (s == STEPS) begin : g_tail
      assign rdy[s] = !v_r[s] || out_ready;
    end else begin : g_mid
      assign rdy[s] = !v_r[s] || rdy[s+1];
    end
  end

  // entry stage: range check against the limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      rem_r[0]  <= word;
      q_r[0]    <= '0;
      over_r[0] <= !(word < accept_limit);
      last_r[0] <= last;
      err_r[0]  <= (size == '0);
    end
  end

  // stage s resolves quotient bit STEPS-s; word < size*quantum keeps quotient in IDX_W bits
  for (genvar s = 1; s <= STEPS; s++) begin : g_stage
    logic [EXT_W-1:0]     dvs;
    logic [EXT_W-1:0]     num;
    logic [EXT_W-1:0]     diff;
    logic                 ge;
    logic [WORD_BITS-1:0] rem_nxt;
    logic [IDX_W-1:0]     q_nxt;

    always_comb begin
      dvs     = {{IDX_W{1'b0}}, quantum} << (STEPS - s);
      num     = {{IDX_W{1'b0}}, rem_r[s-1]};
      diff    = num - dvs;
      ge      = num >= dvs;
      rem_nxt = ge ? diff[WORD_BITS-1:0] : rem_r[s-1];
      q_nxt   = q_r[s-1];
      q_nxt[STEPS-s] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= v_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && v_r[s-1]) begin
        rem_r[s]  <= rem_nxt;
        q_r[s]    <= q_nxt;
        over_r[s] <= over_r[s-1];
        last_r[s] <= last_r[s-1];
        err_r[s]  <= err_r[s-1];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[STEPS];
  assign out_quo   = q_r[STEPS];
  assign out_over  = over_r[STEPS];
  assign out_last  = last_r[STEPS];
  assign out_err   = err_r[STEPS];

endmodule

/* hdl/rwcc_char_map.sv */
// Output stage: maps the alphabet index to ASCII and holds the result beat.
// Depends on rwcc_pkg for the beat type and character set constants.
module rwcc_char_map (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rwcc_pkg::IDX_W-1:0]   quo,
  input  logic                         over,
  input  logic                         last,
  input  logic                         err,
  input  logic [rwcc_pkg::MASK_W-1:0]  mask,
  input  logic [rwcc_pkg::IDX_W-1:0]   size,
  output logic                         out_valid,
  input  logic                         out_ready,
  output rwcc_pkg::out_beat_t          out_data
);
  import rwcc_pkg::*;

  localparam int SYM_N = 32;
  localparam logic [CHAR_W-1:0] SYMBOLS [0:SYM_N-1] = '{
    7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h26, 7'h27, 7'h28, 7'h29, 7'h2A,
    7'h2B, 7'h2C, 7'h2D, 7'h2E, 7'h2F, 7'h3A, 7'h3B, 7'h3C, 7'h3D, 7'h3E,
    7'h3F, 7'h40, 7'h5B, 7'h5C, 7'h5D, 7'h5E, 7'h5F, 7'h60, 7'h7B, 7'h7C,
    7'h7D, 7'h7E
  };

  function automatic logic [CHAR_W-1:0] alphabet_at(input logic [IDX_W-1:0] idx_in,
                                                     input logic [MASK_W-1:0] m);
    logic [IDX_W-1:0]  idx;
    logic [CHAR_W-1:0] ch;
    logic              done;
    idx  = idx_in;
    ch   = '0;
    done = 1'b0;
    if (m[MASK_LOWER]) begin
      if (idx < LOWER_COUNT) begin
        ch   = CHAR_LOWER_A + idx;
        done = 1'b1;
      end else begin
        idx = idx - LOWER_COUNT;
      end
    end
    if (!done && m[MASK_UPPER]) begin
      if (idx < UPPER_COUNT) begin
        ch   = CHAR_UPPER_A + idx;
        done = 1'b1;
      end else begin
        idx = idx - UPPER_COUNT;
      end
    end
    if (!done && m[MASK_DIGIT]) begin
      if (idx < DIGIT_COUNT) begin
        ch   = CHAR_ZERO + idx;
        done = 1'b1;
      end else begin
        idx = idx - DIGIT_COUNT;
      end
    end
    if (!done && m[MASK_SYMBOL] && idx < SYMBOL_COUNT) begin
      ch = SYMBOLS[idx[4:0]];
    end
    return ch;
  endfunction

  logic             valid_r;
  out_beat_t        data_r;
  out_beat_t        data_nxt;
  logic [IDX_W-1:0] idx;

  // at or above the limit, or with an index past the alphabet: last alphabet entry
  always_comb begin
    idx = (over || quo >= size) ? size - 1'b1 : quo;
    data_nxt.character    = err ? '0 : alphabet_at(idx, mask);
    data_nxt.no_set_error = err;
    data_nxt.last_out     = last;
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* hdl/random_word_to_charset_char_core.sv */
// Pipeline: 9 register stages (entry, 7 divide stages, output) from an accepted in_ beat
// to out_valid. Throughput: one beat per cycle unless out_ready or a derivation stalls it;
// each divide stage resolves one index bit with one wide subtract.
// After reset and after each cfg_we with a nonempty mask, quantum/limit are derived serially:
// in_ready stays low until the derivation ends. An empty mask needs no derivation.
// Reset is synchronous (rst_n low): set_mask returns to all four sets, pipeline empties.
module random_word_to_charset_char_core #(
  parameter int WORD_BITS = rwcc_pkg::WORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  rwcc_pkg::in_beat_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output rwcc_pkg::out_beat_t          out_data,
  input  logic                         cfg_we,
  input  logic [rwcc_pkg::MASK_W-1:0]  cfg_wdata
);
  import rwcc_pkg::*;

  cfg_t                 cfg;
  logic [WORD_BITS-1:0] quantum;
  logic [WORD_BITS-1:0] accept_limit;
  logic                 div_in_ready;
  logic                 div_valid;
  logic                 map_ready;
  logic [IDX_W-1:0]     div_quo;
  logic                 div_over;
  logic                 div_last;
  logic                 div_err;

  rwcc_derive #(.WORD_BITS(WORD_BITS)) u_derive (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cfg          (cfg),
    .quantum      (quantum),
    .accept_limit (accept_limit)
  );

  assign in_ready = div_in_ready && !cfg.busy;

  rwcc_div_pipe #(.WORD_BITS(WORD_BITS)) u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid && !cfg.busy),
    .in_ready     (div_in_ready),
    .word         (in_data.random_word[WORD_BITS-1:0]),
    .last         (in_data.last_in),
    .quantum      (quantum),
    .accept_limit (accept_limit),
    .size         (cfg.size),
    .out_valid    (div_valid),
    .out_ready    (map_ready),
    .out_quo      (div_quo),
    .out_over     (div_over),
    .out_last     (div_last),
    .out_err      (div_err)
  );

  rwcc_char_map u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_valid),
    .in_ready  (map_ready),
    .quo       (div_quo),
    .over      (div_over),
    .last      (div_last),
    .err       (div_err),
    .mask      (cfg.mask),
    .size      (cfg.size),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.busy |-> !in_ready)
    else $error("input accepted while quantum derivation runs");

  a_cfg_starts_derive: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_wdata != '0) |=> !in_ready)
    else $error("no derivation after nonempty mask write");

  a_err_zero_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.no_set_error) |-> (out_data.character == '0))
    else $error("character nonzero with empty set mask");

  a_char_printable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.no_set_error) |->
      (out_data.character >= CHAR_FIRST && out_data.character <= CHAR_LAST))
    else $error("character outside printable range");

endmodule

/* test/testbench.sv */
// Self-checking bench for random_word_to_charset_char_core: random words in, characters out.
// Predicts every character from the current set mask; depends only on rwcc_pkg and the core.
module testbench;
  import rwcc_pkg::*;

  localparam int          WORD_BITS    = WORD_BITS_DEF;
  localparam logic [63:0] TOP          = (WORD_BITS == 64) ? '1 : (64'd1 << WORD_BITS) - 1;
  localparam int          SETTLE       = 12;    // pipeline depth plus margin
  localparam int          HOLD_CYCLES  = 150;
  localparam int          STUCK_LIMIT  = 2000;
  localparam int          PER_MASK     = 10;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;
  logic      cfg_we;
  logic [MASK_W-1:0] cfg_wdata;

  // predictor copy of the charset configuration
  logic [MASK_W-1:0] cur_mask;
  logic [IDX_W-1:0]  cur_size;
  logic [63:0]       cur_quantum;
  logic [63:0]       cur_limit;

  out_beat_t pending_chars[$];
  int        err_count;
  int        stuck_cycles;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        hold_req;

  random_word_to_charset_char_core #(.WORD_BITS(WORD_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit is_alnum(logic [6:0] c);
    return (c >= CHAR_ZERO && c < CHAR_ZERO + DIGIT_COUNT) ||
           (c >= CHAR_UPPER_A && c < CHAR_UPPER_A + UPPER_COUNT) ||
           (c >= CHAR_LOWER_A && c < CHAR_LOWER_A + LOWER_COUNT);
  endfunction

  // k-th printable non-alphanumeric character in ASCII order
  function automatic logic [6:0] symbol_at(logic [6:0] k);
    int seen;
    seen = 0;
    for (int i = CHAR_FIRST; i <= CHAR_LAST; i++) begin
      if (!is_alnum(7'(i))) begin
        if (seen == k) return 7'(i);
        seen++;
      end
    end
    return '0;
  endfunction

  function automatic logic [6:0] charset_at(logic [MASK_W-1:0] mask, logic [6:0] idx);
    logic [6:0] k;
    k = idx;
    if (mask[MASK_LOWER]) begin
      if (k < LOWER_COUNT) return CHAR_LOWER_A + k;
      k = k - LOWER_COUNT;
    end
    if (mask[MASK_UPPER]) begin
      if (k < UPPER_COUNT) return CHAR_UPPER_A + k;
      k = k - UPPER_COUNT;
    end
    if (mask[MASK_DIGIT]) begin
      if (k < DIGIT_COUNT) return CHAR_ZERO + k;
      k = k - DIGIT_COUNT;
    end
    if (mask[MASK_SYMBOL] && k < SYMBOL_COUNT) return symbol_at(k);
    return '0;
  endfunction

  function automatic out_beat_t predict_char(logic [63:0] word, logic last);
    out_beat_t  r;
    logic [63:0] w;
    logic [63:0] idx;
    r = '0;
    r.last_out = last;
    w = word & TOP;
    if (cur_size == 0 || cur_quantum == 0) begin
      r.no_set_error = 1'b1;
    end else begin
      // words at or past the limit, the limit itself included, take the last entry
      idx = (w < cur_limit) ? w / cur_quantum : 64'(cur_size) - 1;
      if (idx >= cur_size) idx = 64'(cur_size) - 1;
      r.character = charset_at(cur_mask, idx[6:0]);
    end
    return r;
  endfunction

  function automatic void derive_charset(logic [MASK_W-1:0] mask);
    logic [IDX_W-1:0] n;
    n = '0;
    if (mask[MASK_LOWER])  n = n + LOWER_COUNT;
    if (mask[MASK_UPPER])  n = n + UPPER_COUNT;
    if (mask[MASK_DIGIT])  n = n + DIGIT_COUNT;
    if (mask[MASK_SYMBOL]) n = n + SYMBOL_COUNT;
    cur_mask = mask;
    cur_size = n;
    if (n == 0) begin
      cur_limit   = '0;
      cur_quantum = '0;
    end else begin
      cur_limit   = TOP - (TOP % n);
      cur_quantum = cur_limit / n;
    end
  endfunction

  // mostly uniform words, the rest near the top, the limit, the bucket edges and zero
  function automatic logic [63:0] pick_word();
    logic [63:0] w;
    logic [63:0] k;
    w = {$urandom(), $urandom()};
    if (cur_size != 0) begin
      case ($urandom_range(0, 9))
        5: w = TOP - $urandom_range(0, 200);
        6: w = cur_limit - $urandom_range(0, 2);
        7: begin
          k = $urandom_range(0, cur_size);
          w = cur_quantum * k + $urandom_range(0, 2) - 1;
        end
        8: w = $urandom_range(0, 1000);
        default: ;
      endcase
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (err_count < 40)
      $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
    err_count++;
  endtask

  // result side: compare each accepted beat against the oldest prediction
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch("unexpected beat", out_data, 0);
      end else begin
        want = pending_chars.pop_front();
        if (out_data.character !== want.character)
          report_mismatch("character", out_data.character, want.character);
        if (out_data.no_set_error !== want.no_set_error)
          report_mismatch("no_set_error", out_data.no_set_error, want.no_set_error);
        if (out_data.last_out !== want.last_out)
          report_mismatch("last_out", out_data.last_out, want.last_out);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // receiver: random stalls, plus a long hold-off whenever hold_req moves
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Offer one beat; valid is left high on return so back-to-back beats need no drop.
  task automatic send_word(logic [63:0] word, logic last);
    in_beat_t b;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    b.random_word = word;
    b.last_in     = last;
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_chars.push_back(predict_char(word, last));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_charset(logic [MASK_W-1:0] mask);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we <= 1'b0;
    derive_charset(mask);
  endtask

  task automatic test_reset_charset();
    // all four sets after reset, alphabet of 94
    send_word(64'd0, 1'b0);
    send_word(64'd1, 1'b1);
    send_word(cur_quantum - 1, 1'b0);
    send_word(cur_quantum, 1'b0);
    send_word(cur_limit - 1, 1'b0);
    send_word(cur_limit, 1'b1);
    send_word(cur_limit + 1, 1'b0);
    send_word(TOP, 1'b1);
    send_word(64'h8000_0000_0000_0000, 1'b0);
  endtask

  task automatic test_edge_masks();
    set_charset('0);
    send_word(TOP, 1'b1);
    send_word(64'd0, 1'b0);
    set_charset(4'b0100);                 // digits only, smallest alphabet
    send_word(64'd0, 1'b0);
    send_word(cur_limit - 1, 1'b0);
    send_word(cur_limit, 1'b1);
    send_word(TOP, 1'b0);
    set_charset(4'b1000);                 // symbols only
    send_word(64'd0, 1'b0);
    send_word(cur_limit - 1, 1'b1);
    send_word(TOP, 1'b0);
    set_charset(4'b0001);
    send_word(cur_quantum * 25, 1'b0);
    send_word(cur_quantum * 26 - 1, 1'b1);
  endtask

  task automatic run_mask_sweep(int s_pct, int r_pct);
    logic [MASK_W-1:0] order[16];
    logic [MASK_W-1:0] tmp;
    int j;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < 16; i++) order[i] = MASK_W'(i);
    for (int i = 15; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < 16; i++) begin
      set_charset(order[i]);
      for (int n = 0; n < PER_MASK; n++) send_word(pick_word(), 1'($urandom()));
    end
  endtask

  task automatic test_random_sweeps();
    run_mask_sweep(7, 75);
    run_mask_sweep(75, 7);
    run_mask_sweep(0, 0);
  endtask

  task automatic test_output_hold_off();
    set_charset(MASK_RESET);
    send_idle_pct = 0;
    recv_idle_pct = 20;
    hold_req++;
    for (int n = 0; n < 40; n++) send_word(pick_word(), 1'($urandom()));
    // sender waits here for every pending beat before going on
    wait_drained();
    for (int n = 0; n < 10; n++) send_word(pick_word(), 1'($urandom()));
  endtask

  initial begin
    err_count     = 0;
    stuck_cycles  = 0;
    hold_req      = 0;
    send_idle_pct = 7;
    recv_idle_pct = 75;
    derive_charset(MASK_RESET);
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= MASK_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_charset();
    test_edge_masks();
    test_random_sweeps();
    test_output_hold_off();

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (pending_chars.size() != 0) report_mismatch("beats never delivered", 0, 0);
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
